### rtl/tdm_pkg.sv
`default_nettype none

package tdm_pkg;

   // table size and derived widths
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // fixed field widths
   localparam int DATA_W        = 32;
   localparam int REQ_TYPE_W    = 3;
   localparam int LIMIT_W       = 5;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_INDEX_W = 4;
   localparam int COUNT_W       = 5;
   localparam int MAX_OUT       = 16;
   localparam int NUM_W         = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // miss counters stick at this value
   localparam logic [DATA_W-1:0] MISS_LIMIT = '1;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TOUCH    = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_POLL     = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_GET      = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_SNAPSHOT = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 2'd3;

   // one table entry as held in the RAM
   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] deadline;
      logic [DATA_W-1:0] touch;
      logic [DATA_W-1:0] misses;
      logic [DATA_W-1:0] lateness;
      logic              expired;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // one response item
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [DATA_W-1:0]        entry_key;
      logic [DATA_W-1:0]        entry_deadline_ms;
      logic [DATA_W-1:0]        entry_last_touch_ms;
      logic [DATA_W-1:0]        entry_misses;
      logic [DATA_W-1:0]        entry_max_lateness_ms;
      logic                     entry_expired;
      logic [COUNT_W-1:0]       entry_count;
      logic                     last_of_run;
   } rsp_type;

   // build a response; fields of an absent entry read as zero
   function automatic rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                        input logic                has_entry,
                                        input logic [IDX_W-1:0]    idx,
                                        input entry_type           entry,
                                        input logic [CNT_W-1:0]    count,
                                        input logic                last);
      rsp_type r;
      r             = '0;
      r.status      = status;
      r.entry_count = COUNT_W'(count);
      r.last_of_run = last;
      if (has_entry) begin
         r.entry_index           = ENTRY_INDEX_W'(idx);
         r.entry_key             = entry.key;
         r.entry_deadline_ms     = entry.deadline;
         r.entry_last_touch_ms   = entry.touch;
         r.entry_misses          = entry.misses;
         r.entry_max_lateness_ms = entry.lateness;
         r.entry_expired         = entry.expired;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/tdm_req_if.sv
`default_nettype none

interface tdm_req_if;
   logic                               valid;
   logic                               ready;
   logic [tdm_pkg::REQ_TYPE_W-1:0]     req_type;
   logic [tdm_pkg::DATA_W-1:0]         task_key;
   logic [tdm_pkg::DATA_W-1:0]         deadline_in_ms;
   logic [tdm_pkg::DATA_W-1:0]         now_ms;
   logic [tdm_pkg::LIMIT_W-1:0]        snapshot_limit;

   modport source (output valid, req_type, task_key, deadline_in_ms, now_ms, snapshot_limit,
                   input ready);
   modport sink (input valid, req_type, task_key, deadline_in_ms, now_ms, snapshot_limit,
                 output ready);
endinterface

`default_nettype wire

### rtl/tdm_rsp_if.sv
`default_nettype none

interface tdm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tdm_pkg::STATUS_W-1:0]         status;
   logic [tdm_pkg::ENTRY_INDEX_W-1:0]    entry_index;
   logic [tdm_pkg::DATA_W-1:0]           entry_key;
   logic [tdm_pkg::DATA_W-1:0]           entry_deadline_ms;
   logic [tdm_pkg::DATA_W-1:0]           entry_last_touch_ms;
   logic [tdm_pkg::DATA_W-1:0]           entry_misses;
   logic [tdm_pkg::DATA_W-1:0]           entry_max_lateness_ms;
   logic                                 entry_expired;
   logic [tdm_pkg::COUNT_W-1:0]          entry_count;
   logic                                 last_of_run;

   modport source (output valid, status, entry_index, entry_key, entry_deadline_ms,
                   entry_last_touch_ms, entry_misses, entry_max_lateness_ms,
                   entry_expired, entry_count, last_of_run,
                   input ready);
   modport sink (input valid, status, entry_index, entry_key, entry_deadline_ms,
                 entry_last_touch_ms, entry_misses, entry_max_lateness_ms,
                 entry_expired, entry_count, last_of_run,
                 output ready);
endinterface

`default_nettype wire

### rtl/tdm_ram.sv
`default_nettype none

module tdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port, and a read port whose data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/task_deadline_monitor_table.sv
`default_nettype none

// Channel   Port      Direction  Payload
// request   req_chan  in         req_type, task_key, deadline_in_ms, now_ms, snapshot_limit
// response  rsp_chan  out        status, entry_index, entry_* fields, entry_count, last_of_run
//
// One request at a time; req_chan.ready is high only while the sequencer is idle, and a
// stalled response holds the sequencer until it is taken.
// Key lookup reads the table RAM one entry a cycle. Poll pipes every used entry through
// read, age and update stages. Snapshot reads each entry, loads it into the response and
// waits for that response to be taken before it reads the next entry.
// Synchronous reset empties the table; entry contents are never cleared, only the count.
module task_deadline_monitor_table (
   input  wire logic  clock,
   input  wire logic  reset,
   tdm_req_if.sink    req_chan,
   tdm_rsp_if.source  rsp_chan
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FIND    = 3'd1;
   localparam logic [2:0] S_POLL    = 3'd2;
   localparam logic [2:0] S_SNAP_RD = 3'd3;
   localparam logic [2:0] S_SNAP_LD = 3'd4;
   localparam logic [2:0] S_RSP     = 3'd5;

   // control state
   logic [2:0]                     state_ff, state_in;
   logic [tdm_pkg::CNT_W-1:0]      used_ff, used_in;
   logic [tdm_pkg::CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                           chk_vld_ff, chk_vld_in;
   logic                           p1_vld_ff, p1_vld_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           fresh_ff, fresh_in;

   // payload state
   logic [tdm_pkg::REQ_TYPE_W-1:0] type_ff, type_in;
   logic [tdm_pkg::DATA_W-1:0]     key_ff, key_in;
   logic [tdm_pkg::DATA_W-1:0]     dl_ff, dl_in;
   logic [tdm_pkg::DATA_W-1:0]     now_ff, now_in;
   logic [tdm_pkg::NUM_W-1:0]      snap_n_ff, snap_n_in;
   logic [tdm_pkg::IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [tdm_pkg::IDX_W-1:0]      p1_idx_ff, p1_idx_in;
   tdm_pkg::entry_type             p1_word_ff, p1_word_in;
   logic [tdm_pkg::DATA_W-1:0]     p1_age_ff, p1_age_in;
   tdm_pkg::rsp_type               rsp_ff, rsp_in;

   // RAM port
   logic                           wr_en, rd_en;
   logic [tdm_pkg::IDX_W-1:0]      wr_addr, rd_addr;
   tdm_pkg::entry_type             wr_word, rd_word;
   logic [tdm_pkg::ENTRY_W-1:0]    rd_data;

   // datapath helpers
   logic                           issue, hit, accept, rsp_take;
   logic [tdm_pkg::LIMIT_W-1:0]    lim_eff;
   logic [tdm_pkg::NUM_W-1:0]      snap_n;
   logic [tdm_pkg::DATA_W-1:0]     late;
   logic                           over;
   tdm_pkg::entry_type             new_word, upd_word;

   tdm_ram #(
      .WIDTH (tdm_pkg::ENTRY_W),
      .DEPTH (tdm_pkg::ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word  = tdm_pkg::entry_type'(rd_data);
   assign accept   = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;
   assign issue    = (rd_idx_ff < used_ff);
   assign hit      = chk_vld_ff && (rd_word.key == key_ff);

   // snapshot length: least of used count and limit, limit capped at the burst size
   assign lim_eff = (req_chan.snapshot_limit > tdm_pkg::LIMIT_W'(tdm_pkg::MAX_OUT))
                    ? tdm_pkg::LIMIT_W'(tdm_pkg::MAX_OUT) : req_chan.snapshot_limit;
   assign snap_n  = (tdm_pkg::NUM_W'(used_ff) < tdm_pkg::NUM_W'(lim_eff))
                    ? tdm_pkg::NUM_W'(used_ff) : tdm_pkg::NUM_W'(lim_eff);

   // poll update of the entry in the update pipe stage
   assign over = p1_age_ff > p1_word_ff.deadline;
   assign late = p1_age_ff - p1_word_ff.deadline;

   always_comb begin
      upd_word = p1_word_ff;
      if (over) begin
         if (late > p1_word_ff.lateness) begin
            upd_word.lateness = late;
         end
         if (!p1_word_ff.expired) begin
            upd_word.expired = 1'b1;
            if (p1_word_ff.misses != tdm_pkg::MISS_LIMIT) begin
               upd_word.misses = p1_word_ff.misses + 1'b1;
            end
         end
      end
   end

   // fresh entry for an append
   always_comb begin
      new_word          = '0;
      new_word.key      = key_ff;
      new_word.deadline = dl_ff;
      new_word.touch    = now_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      rd_idx_in    = rd_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      p1_vld_in    = 1'b0;
      p1_idx_in    = p1_idx_ff;
      p1_word_in   = p1_word_ff;
      p1_age_in    = p1_age_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      fresh_in     = fresh_ff;
      type_in      = type_ff;
      key_in       = key_ff;
      dl_in        = dl_ff;
      now_in       = now_ff;
      snap_n_in    = snap_n_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_word      = rd_word;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[tdm_pkg::IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            // capture the request and pick the walk it needs
            if (accept) begin
               type_in   = req_chan.req_type;
               key_in    = req_chan.task_key;
               dl_in     = req_chan.deadline_in_ms;
               now_in    = req_chan.now_ms;
               snap_n_in = snap_n;
               rd_idx_in = '0;
               fresh_in  = 1'b0;
               case (req_chan.req_type)
                  tdm_pkg::REQ_REGISTER: begin
                     if (req_chan.deadline_in_ms == '0) begin
                        rsp_in       = tdm_pkg::make_rsp(tdm_pkg::ST_IGNORED, 1'b0, '0, '0,
                                                         used_ff, 1'b1);
                        rsp_valid_in = 1'b1;
                        state_in     = S_RSP;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  tdm_pkg::REQ_TOUCH, tdm_pkg::REQ_GET: begin
                     state_in = S_FIND;
                  end
                  tdm_pkg::REQ_POLL: begin
                     state_in = S_POLL;
                  end
                  tdm_pkg::REQ_SNAPSHOT: begin
                     if (snap_n == '0) begin
                        rsp_in       = tdm_pkg::make_rsp(tdm_pkg::ST_NOT_FOUND, 1'b0, '0, '0,
                                                         used_ff, 1'b1);
                        rsp_valid_in = 1'b1;
                        state_in     = S_RSP;
                     end else begin
                        state_in = S_SNAP_RD;
                     end
                  end
                  default: begin
                     rsp_in       = tdm_pkg::make_rsp(tdm_pkg::ST_IGNORED, 1'b0, '0, '0,
                                                      used_ff, 1'b1);
                     rsp_valid_in = 1'b1;
                     state_in     = S_RSP;
                  end
               endcase
            end
         end

         S_FIND: begin
            // stream keys one a cycle; stop reading once a key matches
            if (issue && !hit) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[tdm_pkg::IDX_W-1:0];
            end
            if (hit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_RSP;
               case (type_ff)
                  tdm_pkg::REQ_REGISTER: begin
                     wr_word.deadline = dl_ff;
                     wr_en            = 1'b1;
                  end
                  tdm_pkg::REQ_TOUCH: begin
                     wr_word.touch   = now_ff;
                     wr_word.expired = 1'b0;
                     wr_en           = 1'b1;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
               rsp_in = tdm_pkg::make_rsp(tdm_pkg::ST_OK, 1'b1, chk_idx_ff, wr_word,
                                          used_ff, 1'b1);
            end else if (!issue) begin
               // every used entry checked without a match
               rsp_valid_in = 1'b1;
               state_in     = S_RSP;
               if (type_ff == tdm_pkg::REQ_REGISTER) begin
                  if (used_ff >= tdm_pkg::CNT_W'(tdm_pkg::ENTRIES)) begin
                     rsp_in = tdm_pkg::make_rsp(tdm_pkg::ST_IGNORED, 1'b0, '0, '0,
                                                used_ff, 1'b1);
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = used_ff[tdm_pkg::IDX_W-1:0];
                     wr_word = new_word;
                     used_in = used_ff + 1'b1;
                     rsp_in  = tdm_pkg::make_rsp(tdm_pkg::ST_OK, 1'b1,
                                                 used_ff[tdm_pkg::IDX_W-1:0], new_word,
                                                 used_ff + 1'b1, 1'b1);
                  end
               end else begin
                  rsp_in = tdm_pkg::make_rsp(tdm_pkg::ST_NOT_FOUND, 1'b0, '0, '0,
                                             used_ff, 1'b1);
               end
            end
         end

         S_POLL: begin
            // read stage
            if (issue) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[tdm_pkg::IDX_W-1:0];
            end
            // age stage
            if (chk_vld_ff) begin
               p1_vld_in  = 1'b1;
               p1_idx_in  = chk_idx_ff;
               p1_word_in = rd_word;
               p1_age_in  = now_ff - rd_word.touch;
            end
            // update stage
            if (p1_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = p1_idx_ff;
               wr_word = upd_word;
               if (over && !p1_word_ff.expired) begin
                  fresh_in = 1'b1;
               end
            end
            if (!issue && !chk_vld_ff && !p1_vld_ff) begin
               rsp_in       = tdm_pkg::make_rsp(fresh_ff ? tdm_pkg::ST_EXPIRED : tdm_pkg::ST_OK,
                                                1'b0, '0, '0, used_ff, 1'b1);
               rsp_valid_in = 1'b1;
               state_in     = S_RSP;
            end
         end

         S_SNAP_RD: begin
            rd_en      = 1'b1;
            rd_idx_in  = rd_idx_ff + 1'b1;
            chk_idx_in = rd_idx_ff[tdm_pkg::IDX_W-1:0];
            state_in   = S_SNAP_LD;
         end

         S_SNAP_LD: begin
            rsp_in       = tdm_pkg::make_rsp(tdm_pkg::ST_OK, 1'b1, chk_idx_ff, rd_word, used_ff,
                                             tdm_pkg::NUM_W'(rd_idx_ff) == snap_n_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_RSP;
         end

         S_RSP: begin
            // hold the response until taken, then go on with the burst or finish
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (type_ff == tdm_pkg::REQ_SNAPSHOT && !rsp_ff.last_of_run) begin
                  state_in = S_SNAP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rd_idx_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         p1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_idx_ff    <= rd_idx_in;
         chk_vld_ff   <= chk_vld_in;
         p1_vld_ff    <= p1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
      end
      type_ff    <= type_in;
      key_ff     <= key_in;
      dl_ff      <= dl_in;
      now_ff     <= now_in;
      snap_n_ff  <= snap_n_in;
      chk_idx_ff <= chk_idx_in;
      p1_idx_ff  <= p1_idx_in;
      p1_word_ff <= p1_word_in;
      p1_age_ff  <= p1_age_in;
      rsp_ff     <= rsp_in;
   end

   // drive the channels
   assign req_chan.ready                 = (state_ff == S_IDLE);
   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.status                = rsp_ff.status;
   assign rsp_chan.entry_index           = rsp_ff.entry_index;
   assign rsp_chan.entry_key             = rsp_ff.entry_key;
   assign rsp_chan.entry_deadline_ms     = rsp_ff.entry_deadline_ms;
   assign rsp_chan.entry_last_touch_ms   = rsp_ff.entry_last_touch_ms;
   assign rsp_chan.entry_misses          = rsp_ff.entry_misses;
   assign rsp_chan.entry_max_lateness_ms = rsp_ff.entry_max_lateness_ms;
   assign rsp_chan.entry_expired         = rsp_ff.entry_expired;
   assign rsp_chan.entry_count           = rsp_ff.entry_count;
   assign rsp_chan.last_of_run           = rsp_ff.last_of_run;

endmodule

`default_nettype wire

### tb/task_deadline_monitor_table_tb.sv
`timescale 1ns / 100ps

module task_deadline_monitor_table_tb;

   // request codes the block does not define
   localparam logic [tdm_pkg::REQ_TYPE_W-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [tdm_pkg::REQ_TYPE_W-1:0] REQ_SPARE_B = 3'd6;
   localparam logic [tdm_pkg::REQ_TYPE_W-1:0] REQ_SPARE_C = 3'd7;

   localparam int RANDOM_REQS = 160;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic [tdm_pkg::REQ_TYPE_W-1:0] kind;
      logic [tdm_pkg::DATA_W-1:0]     key;
      logic [tdm_pkg::DATA_W-1:0]     deadline;
      logic [tdm_pkg::DATA_W-1:0]     now;
      logic [tdm_pkg::LIMIT_W-1:0]    limit;
   } watch_req_type;

   typedef struct {
      logic [tdm_pkg::DATA_W-1:0] key;
      logic [tdm_pkg::DATA_W-1:0] deadline;
      logic [tdm_pkg::DATA_W-1:0] touch;
      logic [tdm_pkg::DATA_W-1:0] misses;
      logic [tdm_pkg::DATA_W-1:0] lateness;
      logic                       expired;
   } watch_slot_type;

   logic clock;
   logic reset;

   tdm_req_if req_if ();
   tdm_rsp_if rsp_if ();

   task_deadline_monitor_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predicted table contents
   watch_slot_type slots [tdm_pkg::ENTRIES];
   int unsigned slots_used;

   watch_req_type              pending_reqs [$];
   tdm_pkg::rsp_type           awaited_rsps [$];
   logic [tdm_pkg::DATA_W-1:0] live_keys [$];
   logic [tdm_pkg::DATA_W-1:0] gen_now_ms;

   int  total_reqs;
   int  reqs_accepted;
   int  rsps_seen;
   int  fault_count;
   bit  req_taken;
   bit  calm;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // known values on every input from the start
   initial begin
      req_if.valid          = 1'b0;
      req_if.req_type       = '0;
      req_if.task_key       = '0;
      req_if.deadline_in_ms = '0;
      req_if.now_ms         = '0;
      req_if.snapshot_limit = '0;
      rsp_if.ready          = 1'b0;
   end

   task automatic report_fault(input string what);
      $display("ERROR %0t: %s", $time, what);
      fault_count++;
   endtask

   task automatic match_field(input string name, input logic [tdm_pkg::DATA_W-1:0] seen,
                              input logic [tdm_pkg::DATA_W-1:0] wanted);
      if (seen !== wanted) begin
         report_fault($sformatf("response %0d %s: got %h, want %h",
                                rsps_seen, name, seen, wanted));
      end
   endtask

   function automatic int locate_key(input logic [tdm_pkg::DATA_W-1:0] key);
      for (int i = 0; i < slots_used; i++) begin
         if (slots[i].key == key) return i;
      end
      return -1;
   endfunction

   // form one response; a negative index reports no entry
   function automatic tdm_pkg::rsp_type build_answer(input logic [tdm_pkg::STATUS_W-1:0] st,
                                                     input int idx, input logic last);
      tdm_pkg::rsp_type r;
      r             = '0;
      r.status      = st;
      r.entry_count = tdm_pkg::COUNT_W'(slots_used);
      r.last_of_run = last;
      if (idx >= 0) begin
         r.entry_index           = tdm_pkg::ENTRY_INDEX_W'(idx);
         r.entry_key             = slots[idx].key;
         r.entry_deadline_ms     = slots[idx].deadline;
         r.entry_last_touch_ms   = slots[idx].touch;
         r.entry_misses          = slots[idx].misses;
         r.entry_max_lateness_ms = slots[idx].lateness;
         r.entry_expired         = slots[idx].expired;
      end
      return r;
   endfunction

   // update the table for one accepted request and queue its responses
   task automatic apply_request(input watch_req_type r);
      int idx;
      int unsigned n;
      logic [tdm_pkg::DATA_W-1:0] age;
      logic [tdm_pkg::DATA_W-1:0] late;
      bit fresh;
      case (r.kind)
         tdm_pkg::REQ_REGISTER: begin
            idx = locate_key(r.key);
            if (r.deadline == '0) begin
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_IGNORED, -1, 1'b1));
            end else if (idx >= 0) begin
               slots[idx].deadline = r.deadline;
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_OK, idx, 1'b1));
            end else if (slots_used >= tdm_pkg::ENTRIES) begin
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_IGNORED, -1, 1'b1));
            end else begin
               idx = slots_used;
               slots[idx].key      = r.key;
               slots[idx].deadline = r.deadline;
               slots[idx].touch    = r.now;
               slots[idx].misses   = '0;
               slots[idx].lateness = '0;
               slots[idx].expired  = 1'b0;
               slots_used++;
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_OK, idx, 1'b1));
            end
         end
         tdm_pkg::REQ_TOUCH: begin
            idx = locate_key(r.key);
            if (idx < 0) begin
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_NOT_FOUND, -1, 1'b1));
            end else begin
               slots[idx].touch   = r.now;
               slots[idx].expired = 1'b0;
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_OK, idx, 1'b1));
            end
         end
         tdm_pkg::REQ_POLL: begin
            fresh = 1'b0;
            for (int i = 0; i < slots_used; i++) begin
               age = r.now - slots[i].touch;
               if (age > slots[i].deadline) begin
                  late = age - slots[i].deadline;
                  if (late > slots[i].lateness) slots[i].lateness = late;
                  if (!slots[i].expired) begin
                     slots[i].expired = 1'b1;
                     if (slots[i].misses != tdm_pkg::MISS_LIMIT) slots[i].misses++;
                     fresh = 1'b1;
                  end
               end
            end
            awaited_rsps.push_back(build_answer(fresh ? tdm_pkg::ST_EXPIRED : tdm_pkg::ST_OK,
                                                -1, 1'b1));
         end
         tdm_pkg::REQ_GET: begin
            idx = locate_key(r.key);
            awaited_rsps.push_back(build_answer(idx < 0 ? tdm_pkg::ST_NOT_FOUND : tdm_pkg::ST_OK,
                                                idx, 1'b1));
         end
         tdm_pkg::REQ_SNAPSHOT: begin
            n = slots_used;
            if (n > r.limit) n = 32'(r.limit);
            if (n > tdm_pkg::MAX_OUT) n = tdm_pkg::MAX_OUT;
            if (n == 0) begin
               awaited_rsps.push_back(build_answer(tdm_pkg::ST_NOT_FOUND, -1, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  awaited_rsps.push_back(build_answer(tdm_pkg::ST_OK, i, i + 1 == n));
               end
            end
         end
         default: begin
            awaited_rsps.push_back(build_answer(tdm_pkg::ST_IGNORED, -1, 1'b1));
         end
      endcase
   endtask

   // queue a request and track which keys it will leave in the table
   task automatic queue_request(input logic [tdm_pkg::REQ_TYPE_W-1:0] kind,
                                input logic [tdm_pkg::DATA_W-1:0] key,
                                input logic [tdm_pkg::DATA_W-1:0] dl,
                                input logic [tdm_pkg::DATA_W-1:0] now,
                                input logic [tdm_pkg::LIMIT_W-1:0] lim);
      watch_req_type r;
      bit known;
      r.kind     = kind;
      r.key      = key;
      r.deadline = dl;
      r.now      = now;
      r.limit    = lim;
      pending_reqs.push_back(r);
      if (kind == tdm_pkg::REQ_REGISTER && dl != '0) begin
         known = 1'b0;
         foreach (live_keys[i]) if (live_keys[i] == key) known = 1'b1;
         if (!known && live_keys.size() < tdm_pkg::ENTRIES) live_keys.push_back(key);
      end
   endtask

   function automatic logic [tdm_pkg::DATA_W-1:0] pick_key();
      if (live_keys.size() == 0 || $urandom_range(99) < 15) return $urandom;
      return live_keys[$urandom_range(live_keys.size() - 1)];
   endfunction

   function automatic logic [tdm_pkg::DATA_W-1:0] pick_deadline();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 14) return $urandom;
      if (roll < 18) return '1;
      return $urandom_range(1500, 1);
   endfunction

   // stimulus, then wait for the table to drain
   initial begin
      int unsigned sel;
      logic [tdm_pkg::DATA_W-1:0] key;
      slots_used  = 0;
      fault_count = 0;
      reqs_accepted = 0;
      rsps_seen   = 0;

      // empty table: nothing to find, report or poll
      queue_request(tdm_pkg::REQ_SNAPSHOT, 32'h0, 32'h0, 32'h0, 5'd16);
      queue_request(tdm_pkg::REQ_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      queue_request(tdm_pkg::REQ_GET, 32'h0, 32'h0, 32'h0, 5'd0);
      queue_request(tdm_pkg::REQ_TOUCH, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0);
      // zero deadline is ignored, then extremes of key and deadline
      queue_request(tdm_pkg::REQ_REGISTER, 32'h0, 32'h0, 32'h0, 5'd0);
      queue_request(tdm_pkg::REQ_REGISTER, 32'h0, 32'h1, 32'h0, 5'd0);
      queue_request(tdm_pkg::REQ_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16);
      queue_request(tdm_pkg::REQ_REGISTER, 32'h0, 32'h5, 32'h1234_5678, 5'd0);
      // first poll expires, second raises lateness only, third lowers nothing
      queue_request(tdm_pkg::REQ_POLL, 32'h0, 32'h0, 32'd10, 5'd0);
      queue_request(tdm_pkg::REQ_POLL, 32'h0, 32'h0, 32'd20, 5'd0);
      queue_request(tdm_pkg::REQ_POLL, 32'h0, 32'h0, 32'd8, 5'd0);
      queue_request(tdm_pkg::REQ_GET, 32'h0, 32'h0, 32'h0, 5'd0);
      queue_request(tdm_pkg::REQ_TOUCH, 32'h0, 32'h0, 32'd30, 5'd0);
      queue_request(tdm_pkg::REQ_SNAPSHOT, 32'h0, 32'h0, 32'h0, 5'd0);
      queue_request(tdm_pkg::REQ_SNAPSHOT, 32'h0, 32'h0, 32'h0, 5'd1);
      // undefined codes change nothing
      queue_request(REQ_SPARE_A, 32'h0, 32'h1, 32'h0, 5'd0);
      queue_request(REQ_SPARE_B, 32'hFFFF_FFFF, 32'h1, 32'h0, 5'd16);
      queue_request(REQ_SPARE_C, 32'h5A5A_5A5A, 32'h1, 32'h0, 5'd1);
      // age wraps past 2^31 and across zero
      queue_request(tdm_pkg::REQ_REGISTER, 32'hA5A5_A5A5, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0);
      queue_request(tdm_pkg::REQ_POLL, 32'h0, 32'h0, 32'h7FFF_FFF0, 5'd0);
      queue_request(tdm_pkg::REQ_SNAPSHOT, 32'h0, 32'h0, 32'h0, 5'd16);

      // random traffic around a running millisecond clock
      gen_now_ms = 32'h7FFF_FFF0;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if ($urandom_range(99) < 5) gen_now_ms = $urandom;
         else gen_now_ms += $urandom_range(400, 0);
         sel = $urandom_range(99);
         if (sel < 25) begin
            if ((live_keys.size() < tdm_pkg::ENTRIES && $urandom_range(99) < 60) ||
                $urandom_range(99) < 20) key = $urandom;
            else key = pick_key();
            queue_request(tdm_pkg::REQ_REGISTER, key, pick_deadline(), gen_now_ms,
                          tdm_pkg::LIMIT_W'($urandom_range(16)));
         end else if (sel < 45) begin
            queue_request(tdm_pkg::REQ_TOUCH, pick_key(), $urandom, gen_now_ms,
                          tdm_pkg::LIMIT_W'($urandom));
         end else if (sel < 70) begin
            queue_request(tdm_pkg::REQ_POLL, $urandom, $urandom, gen_now_ms,
                          tdm_pkg::LIMIT_W'($urandom));
         end else if (sel < 85) begin
            queue_request(tdm_pkg::REQ_GET, pick_key(), $urandom, gen_now_ms,
                          tdm_pkg::LIMIT_W'($urandom));
         end else begin
            queue_request(tdm_pkg::REQ_SNAPSHOT, $urandom, $urandom, gen_now_ms,
                          tdm_pkg::LIMIT_W'($urandom_range(16)));
         end
      end
      total_reqs = pending_reqs.size();

      // drain: every request taken, every response seen, then settle
      while (reset || reqs_accepted < total_reqs) @(posedge clock);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("task_deadline_monitor_table_tb: clean");
      end else begin
         $display("task_deadline_monitor_table_tb: errors");
      end
      $finish;
   end

   // generous limit on the whole run
   initial begin
      #5_000_000;
      $display("task_deadline_monitor_table_tb: errors");
      $finish;
   end

   // no idling while the middle of the run goes through
   always @(posedge clock) begin
      calm = (reqs_accepted >= 70 && reqs_accepted < 130);
   end

   // take requests into the table prediction
   always @(posedge clock) begin
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken) begin
         apply_request('{req_if.req_type, req_if.task_key, req_if.deadline_in_ms,
                         req_if.now_ms, req_if.snapshot_limit});
         reqs_accepted++;
      end
   end

   // request driver: hold until taken, otherwise advance or idle
   always @(negedge clock) begin
      watch_req_type r;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // hold the current request
      end else if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
         r = pending_reqs.pop_front();
         req_if.valid          <= 1'b1;
         req_if.req_type       <= r.kind;
         req_if.task_key       <= r.key;
         req_if.deadline_in_ms <= r.deadline;
         req_if.now_ms         <= r.now;
         req_if.snapshot_limit <= r.limit;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 30);
      end
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin
      tdm_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsps.size() == 0) begin
            report_fault($sformatf("response %0d arrived with none predicted", rsps_seen));
         end else begin
            want = awaited_rsps.pop_front();
            match_field("status", tdm_pkg::DATA_W'(rsp_if.status),
                        tdm_pkg::DATA_W'(want.status));
            match_field("entry_index", tdm_pkg::DATA_W'(rsp_if.entry_index),
                        tdm_pkg::DATA_W'(want.entry_index));
            match_field("entry_key", rsp_if.entry_key, want.entry_key);
            match_field("entry_deadline_ms", rsp_if.entry_deadline_ms, want.entry_deadline_ms);
            match_field("entry_last_touch_ms", rsp_if.entry_last_touch_ms,
                        want.entry_last_touch_ms);
            match_field("entry_misses", rsp_if.entry_misses, want.entry_misses);
            match_field("entry_max_lateness_ms", rsp_if.entry_max_lateness_ms,
                        want.entry_max_lateness_ms);
            match_field("entry_expired", tdm_pkg::DATA_W'(rsp_if.entry_expired),
                        tdm_pkg::DATA_W'(want.entry_expired));
            match_field("entry_count", tdm_pkg::DATA_W'(rsp_if.entry_count),
                        tdm_pkg::DATA_W'(want.entry_count));
            match_field("last_of_run", tdm_pkg::DATA_W'(rsp_if.last_of_run),
                        tdm_pkg::DATA_W'(want.last_of_run));
         end
         rsps_seen++;
      end
   end

endmodule
